// ----- rtl/bayer_bilinear_demosaic_unit_defines.svh -----
// Assertion macros for the Bayer demosaic unit.
`ifndef BAYER_BILINEAR_DEMOSAIC_UNIT_DEFINES_SVH
`define BAYER_BILINEAR_DEMOSAIC_UNIT_DEFINES_SVH
`ifndef SYNTH
`define BBD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BBD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define BBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/bbd_pkg.sv -----
// Shared types, constants and functions of the Bayer demosaic unit.
package bbd_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 12;
    localparam int OUT_COORD_W = 11;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int WDIM_W      = COL_W + 1;
    localparam int HDIM_W      = ROW_W + 1;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int EMIT_KINDS  = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Which output pixel an input sample completes, relative to the sample.
    typedef enum logic [1:0] {
        EMIT_UP_LEFT  = 2'd0,
        EMIT_UP_EDGE  = 2'd1,
        EMIT_CUR_LEFT = 2'd2,
        EMIT_CUR_EDGE = 2'd3
    } t_emit;

    // [row][col], row 0 oldest line, col 0 oldest column
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

    typedef struct packed {
        t_win                  win;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic [EMIT_KINDS-1:0] mask;
    } t_job;

    function automatic logic [WDIM_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
        int x;
        x = int'(v);
        if (x < 2) x = 2;
        if (x > MAX_WIDTH) x = MAX_WIDTH;
        return WDIM_W'(x);
    endfunction

    function automatic logic [HDIM_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
        int x;
        x = int'(v);
        if (x < 2) x = 2;
        if (x > MAX_HEIGHT) x = MAX_HEIGHT;
        return HDIM_W'(x);
    endfunction

endpackage

// ----- rtl/bbd_front.sv -----
// Front end: sample intake, line stores, 3x3 window and job classification.
`include "bayer_bilinear_demosaic_unit_defines.svh"
module bbd_front import bbd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_raw_pixel,
    output logic             o_stall,
    input  logic             i_restart,
    input  logic [COL_W-1:0] i_last_col,
    input  logic [ROW_W-1:0] i_last_row,
    input  logic             i_full,
    output logic             o_push,
    output t_job             o_job
);

    logic [PIX_W-1:0] r_older_line [MAX_WIDTH];
    logic [PIX_W-1:0] r_newer_line [MAX_WIDTH];

    logic [COL_W-1:0] r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic [COL_W-1:0] n_in_col;
    logic [ROW_W-1:0] n_in_row;

    logic             r_f1_valid;
    logic [PIX_W-1:0] r_f1_px;
    logic [COL_W-1:0] r_f1_col;
    logic [ROW_W-1:0] r_f1_row;
    logic [PIX_W-1:0] r_rd_older;
    logic [PIX_W-1:0] r_rd_newer;
    t_win             r_win;
    t_win             n_win;

    logic                  accept;
    logic                  f1_adv;
    logic [EMIT_KINDS-1:0] mask;
    logic                  row_nz;
    logic                  col_nz;
    logic                  col_last;
    logic                  row_last;

    assign row_nz   = (r_f1_row != '0);
    assign col_nz   = (r_f1_col != '0);
    assign col_last = (r_f1_col == i_last_col);
    assign row_last = (r_f1_row == i_last_row);

    always_comb begin
        mask                = '0;
        mask[EMIT_UP_LEFT]  = row_nz & col_nz;
        mask[EMIT_UP_EDGE]  = row_nz & col_last;
        mask[EMIT_CUR_LEFT] = row_last & col_nz;
        mask[EMIT_CUR_EDGE] = row_last & col_last;
    end

    assign f1_adv  = r_f1_valid && ((mask == '0) || !i_full);
    assign o_stall = r_f1_valid && !f1_adv;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k][0] = r_win[k][1];
            n_win[k][1] = r_win[k][2];
        end
        n_win[0][2] = r_rd_older;
        n_win[1][2] = r_rd_newer;
        n_win[2][2] = r_f1_px;
    end

    always_comb begin
        n_in_col = r_in_col + COL_W'(1);
        n_in_row = r_in_row;
        if (r_in_col >= i_last_col) begin
            n_in_col = '0;
            n_in_row = (r_in_row >= i_last_row) ? '0 : r_in_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_f1_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            if (i_restart) begin
                r_in_col <= '0;
                r_in_row <= '0;
            end else if (accept) begin
                r_in_col <= n_in_col;
                r_in_row <= n_in_row;
            end
            r_f1_valid <= accept || (r_f1_valid && !f1_adv);
            if (f1_adv) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_px  <= i_raw_pixel;
            r_f1_col <= r_in_col;
            r_f1_row <= r_in_row;
        end
    end

    // Line stores: read at intake, written back when the sample leaves F1.
    always_ff @(posedge i_clk) begin
        if (f1_adv) begin
            r_older_line[r_f1_col] <= r_rd_newer;
            r_newer_line[r_f1_col] <= r_f1_px;
        end
        if (accept) begin
            r_rd_older <= r_older_line[r_in_col];
            r_rd_newer <= r_newer_line[r_in_col];
        end
    end

    assign o_push   = f1_adv && (mask != '0);
    assign o_job.win  = n_win;
    assign o_job.row  = r_f1_row;
    assign o_job.col  = r_f1_col;
    assign o_job.mask = mask;

    `BBD_ASSERT_IMPLIES(a_front_row0_silent, i_clk, i_rst_n, o_push, r_f1_row != '0, "row 0 job")

endmodule

// ----- rtl/bbd_fifo.sv -----
// Short job queue between front and back ends.
`include "bayer_bilinear_demosaic_unit_defines.svh"
module bbd_fifo import bbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (FIFO_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (FIFO_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `BBD_ASSERT_IMPLIES(a_fifo_no_overflow, i_clk, i_rst_n, i_push, !o_full, "queue overflow")
    `BBD_ASSERT_IMPLIES(a_fifo_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "queue underflow")
    `BBD_ASSERT_NEXT(a_fifo_drains, i_clk, i_rst_n, i_pop && !i_push && r_count == (FIFO_AW+1)'(1), o_empty, "count slip")

endmodule

// ----- rtl/bbd_back.sv -----
// Back end: expands each job into output pixels and interpolates colors.
`include "bayer_bilinear_demosaic_unit_defines.svh"
module bbd_back import bbd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  t_job                   i_job,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [PIX_W-1:0]       o_red,
    output logic [PIX_W-1:0]       o_green,
    output logic [PIX_W-1:0]       o_blue,
    output logic [OUT_COORD_W-1:0] o_out_row,
    output logic [OUT_COORD_W-1:0] o_out_col,
    output logic                   o_last_of_run,
    output logic                   o_end_of_frame
);

    logic [EMIT_KINDS-1:0]  r_used;
    logic                   r_out_valid;
    logic [PIX_W-1:0]       r_red;
    logic [PIX_W-1:0]       r_green;
    logic [PIX_W-1:0]       r_blue;
    logic [OUT_COORD_W-1:0] r_row;
    logic [OUT_COORD_W-1:0] r_col;
    logic                   r_last;
    logic                   r_eof;

    logic [EMIT_KINDS-1:0] avail;
    logic [EMIT_KINDS-1:0] rest;
    t_emit                 kind;
    logic                  last;
    logic                  load;
    logic                  cur_row;
    logic                  edge_col;
    logic                  top;
    logic                  left;
    logic [ROW_W-1:0]      pr;
    logic [COL_W-1:0]      pc;
    logic [1:0]            up_r, mid_r, dn_r, lf_c, mid_c, rt_c;
    logic [PIX_W-1:0]      ctr;
    logic [PIX_W:0]        hz;
    logic [PIX_W:0]        vt;
    logic [PIX_W+1:0]      hv;
    logic [PIX_W+1:0]      dg;
    logic [PIX_W-1:0]      red, green, blue;

    assign avail = i_job.mask & ~r_used;

    always_comb begin
        kind = EMIT_CUR_EDGE;
        if (avail[EMIT_CUR_LEFT]) kind = EMIT_CUR_LEFT;
        if (avail[EMIT_UP_EDGE])  kind = EMIT_UP_EDGE;
        if (avail[EMIT_UP_LEFT])  kind = EMIT_UP_LEFT;
        rest       = avail;
        rest[kind] = 1'b0;
    end

    assign last     = (rest == '0);
    assign load     = !i_empty && (!r_out_valid || !i_stall);
    assign o_pop    = load && last;
    assign cur_row  = (kind == EMIT_CUR_LEFT) || (kind == EMIT_CUR_EDGE);
    assign edge_col = (kind == EMIT_UP_EDGE) || (kind == EMIT_CUR_EDGE);

    assign pr   = cur_row ? i_job.row : i_job.row - ROW_W'(1);
    assign pc   = edge_col ? i_job.col : i_job.col - COL_W'(1);
    assign top  = !cur_row && (i_job.row == ROW_W'(1));
    assign left = !edge_col && (i_job.col == COL_W'(1));

    // Neighbor taps with mirrored borders.
    always_comb begin
        mid_r = cur_row ? 2'd2 : 2'd1;
        up_r  = cur_row ? 2'd1 : (top ? 2'd2 : 2'd0);
        dn_r  = cur_row ? 2'd1 : 2'd2;
        mid_c = edge_col ? 2'd2 : 2'd1;
        lf_c  = edge_col ? 2'd1 : (left ? 2'd2 : 2'd0);
        rt_c  = edge_col ? 2'd1 : 2'd2;
    end

    always_comb begin
        ctr = i_job.win[mid_r][mid_c];
        hz  = {1'b0, i_job.win[mid_r][lf_c]} + {1'b0, i_job.win[mid_r][rt_c]};
        vt  = {1'b0, i_job.win[up_r][mid_c]} + {1'b0, i_job.win[dn_r][mid_c]};
        hv  = {1'b0, hz} + {1'b0, vt};
        dg  = {2'b00, i_job.win[up_r][lf_c]} + {2'b00, i_job.win[up_r][rt_c]}
            + {2'b00, i_job.win[dn_r][lf_c]} + {2'b00, i_job.win[dn_r][rt_c]};
        case ({pr[0], pc[0]})
            2'b00: begin
                red = ctr; green = hv[PIX_W+1:2]; blue = dg[PIX_W+1:2];
            end
            2'b01: begin
                red = hz[PIX_W:1]; green = ctr; blue = vt[PIX_W:1];
            end
            2'b10: begin
                red = vt[PIX_W:1]; green = ctr; blue = hz[PIX_W:1];
            end
            default: begin
                red = dg[PIX_W+1:2]; green = hv[PIX_W+1:2]; blue = ctr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_out_valid || !i_stall) begin
                r_out_valid <= !i_empty;
            end
            if (load) begin
                if (last) begin
                    r_used <= '0;
                end else begin
                    r_used <= r_used | (avail & ~rest);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_red   <= red;
            r_green <= green;
            r_blue  <= blue;
            r_row   <= OUT_COORD_W'(pr);
            r_col   <= OUT_COORD_W'(pc);
            r_last  <= last;
            r_eof   <= (kind == EMIT_CUR_EDGE);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_out_row      = r_row;
    assign o_out_col      = r_col;
    assign o_last_of_run  = r_last;
    assign o_end_of_frame = r_eof;

    `BBD_ASSERT_IMPLIES(a_back_eof_last, i_clk, i_rst_n, r_out_valid && r_eof, r_last, "eof not last")
    `BBD_ASSERT_IMPLIES(a_back_used_job, i_clk, i_rst_n, r_used != '0, !i_empty, "stale job")

endmodule

// ----- rtl/bayer_bilinear_demosaic_unit.sv -----
// Top level of the bilinear RGGB Bayer demosaic unit.
// Usage:
//   Input channel: i_valid / o_stall / i_raw_pixel, one raw sample per
//   transaction in raster order, RGGB phase at row 0 column 0.
//   Output channel: o_valid / i_stall and the pixel fields; every sample
//   from row 1 on past column 0 completes one output pixel of the row above
//   (two at the last column), and on the last row also pixels of that row,
//   so the final sample of a frame gives four transactions. last_of_run
//   marks the last pixel caused by one sample, end_of_frame the bottom right.
//   Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; any write restarts the frame at row 0 column 0.
//   A sample is registered in F1, queued as a job, and each result is
//   registered at the output. Throughput: one sample per cycle while o_stall
//   is low; on the last row each sample gives two results at one result per
//   cycle, so once the four-entry job queue fills, o_stall slows the input.
//   Line stores: one read at intake, one write when the sample leaves F1.
//   Reset: frame 640 x 480, counters and window cleared, no results pending.
//   When the receiver stalls, the output holds and the queue fills, then
//   o_stall rises; no result is lost.
module bayer_bilinear_demosaic_unit import bbd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [PIX_W-1:0]       i_raw_pixel,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [PIX_W-1:0]       o_red,
    output logic [PIX_W-1:0]       o_green,
    output logic [PIX_W-1:0]       o_blue,
    output logic [OUT_COORD_W-1:0] o_out_row,
    output logic [OUT_COORD_W-1:0] o_out_col,
    output logic                   o_last_of_run,
    output logic                   o_end_of_frame,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    logic [WDIM_W-1:0] r_frame_width;
    logic [HDIM_W-1:0] r_frame_height;
    logic [WDIM_W-1:0] last_col_full;
    logic [HDIM_W-1:0] last_row_full;
    logic              cfg_wr;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job push_job;
    t_job head_job;

    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid && o_cfg_ready;
    assign last_col_full = r_frame_width - WDIM_W'(1);
    assign last_row_full = r_frame_height - HDIM_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WDIM_W'(RESET_WIDTH);
            r_frame_height <= HDIM_W'(RESET_HEIGHT);
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= clamp_width(i_cfg_data);
                CFG_FRAME_HEIGHT: r_frame_height <= clamp_height(i_cfg_data);
                default: ;
            endcase
        end
    end

    bbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_raw_pixel (i_raw_pixel),
        .o_stall     (o_stall),
        .i_restart   (cfg_wr),
        .i_last_col  (last_col_full[COL_W-1:0]),
        .i_last_row  (last_row_full[ROW_W-1:0]),
        .i_full      (full),
        .o_push      (push),
        .o_job       (push_job)
    );

    bbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (head_job)
    );

    bbd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_job          (head_job),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
